// ----- rtl/core/clns_pkg.sv -----
`default_nettype none
package clns_pkg;

	localparam int unsigned TIME_W   = 16;
	localparam int unsigned POST_W   = 17;
	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [2:0] {
		OP_INIT   = 3'd0,
		OP_CMD    = 3'd1,
		OP_DATA   = 3'd2,
		OP_CLEAR  = 3'd3,
		OP_CURSOR = 3'd4
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE_HIGH = 3'd0,
		CFG_HOLD_AFTER  = 3'd1,
		CFG_POWER_ON    = 3'd2,
		CFG_WAKE_WAIT   = 3'd3,
		CFG_CLEAR_WAIT  = 3'd4
	} cfg_idx_t;

	localparam logic [TIME_W-1:0] RST_ENABLE_HIGH = 16'd200;
	localparam logic [TIME_W-1:0] RST_HOLD_AFTER  = 16'd4000;
	localparam logic [TIME_W-1:0] RST_POWER_ON    = 16'd50000;
	localparam logic [TIME_W-1:0] RST_WAKE_WAIT   = 16'd5000;
	localparam logic [TIME_W-1:0] RST_CLEAR_WAIT  = 16'd2000;

	typedef struct packed {
		logic [TIME_W-1:0] enable_high_time;
		logic [TIME_W-1:0] hold_after_pulse;
		logic [TIME_W-1:0] power_on_wait;
		logic [TIME_W-1:0] wake_nibble_wait;
		logic [TIME_W-1:0] clear_wait;
	} cfg_t;

	// nibble source of one microcode step
	typedef enum logic [1:0] {
		NS_CONST   = 2'd0,
		NS_BYTE_HI = 2'd1,
		NS_BYTE_LO = 2'd2
	} nib_src_t;

	// extra wait added to the hold time
	typedef enum logic [1:0] {
		EX_NONE  = 2'd0,
		EX_WAKE  = 2'd1,
		EX_CLEAR = 2'd2
	} extra_t;

	typedef struct packed {
		logic     rs;
		nib_src_t nsrc;
		logic [3:0] cnib;
		logic     pre_power;
		extra_t   extra;
		logic     last;
	} uword_t;

	localparam int unsigned ROM_DEPTH = 20;
	localparam int unsigned PC_W      = $clog2(ROM_DEPTH);

	localparam logic [PC_W-1:0] ENTRY_INIT   = 5'd0;
	localparam logic [PC_W-1:0] ENTRY_CMD    = 5'd12;
	localparam logic [PC_W-1:0] ENTRY_DATA   = 5'd14;
	localparam logic [PC_W-1:0] ENTRY_CLEAR  = 5'd16;
	localparam logic [PC_W-1:0] ENTRY_CURSOR = 5'd18;

	// control handed from the sequencer to the datapath
	typedef struct packed {
		logic       fire;
		uword_t     word;
		logic [7:0] byte_q;
	} ctl_t;

	typedef struct packed {
		logic busy;
	} seq_stat_t;

	function automatic uword_t mk(input logic rs, input nib_src_t nsrc, input logic [3:0] cnib,
		input logic pre_power, input extra_t extra, input logic last);
		uword_t w;
		w.rs        = rs;
		w.nsrc      = nsrc;
		w.cnib      = cnib;
		w.pre_power = pre_power;
		w.extra     = extra;
		w.last      = last;
		return w;
	endfunction

	function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
		uword_t w;
		case (pc)
			5'd0:    w = mk(1'b0, NS_CONST,   4'h3, 1'b1, EX_WAKE,  1'b0);
			5'd1:    w = mk(1'b0, NS_CONST,   4'h3, 1'b0, EX_WAKE,  1'b0);
			5'd2:    w = mk(1'b0, NS_CONST,   4'h3, 1'b0, EX_WAKE,  1'b0);
			5'd3:    w = mk(1'b0, NS_CONST,   4'h2, 1'b0, EX_NONE,  1'b0);
			5'd4:    w = mk(1'b0, NS_CONST,   4'h2, 1'b0, EX_NONE,  1'b0);
			5'd5:    w = mk(1'b0, NS_CONST,   4'h8, 1'b0, EX_NONE,  1'b0);
			5'd6:    w = mk(1'b0, NS_CONST,   4'h0, 1'b0, EX_NONE,  1'b0);
			5'd7:    w = mk(1'b0, NS_CONST,   4'hC, 1'b0, EX_NONE,  1'b0);
			5'd8:    w = mk(1'b0, NS_CONST,   4'h0, 1'b0, EX_NONE,  1'b0);
			5'd9:    w = mk(1'b0, NS_CONST,   4'h6, 1'b0, EX_NONE,  1'b0);
			5'd10:   w = mk(1'b0, NS_CONST,   4'h0, 1'b0, EX_NONE,  1'b0);
			5'd11:   w = mk(1'b0, NS_CONST,   4'h1, 1'b0, EX_CLEAR, 1'b1);
			5'd12:   w = mk(1'b0, NS_BYTE_HI, 4'h0, 1'b0, EX_NONE,  1'b0);
			5'd13:   w = mk(1'b0, NS_BYTE_LO, 4'h0, 1'b0, EX_NONE,  1'b1);
			5'd14:   w = mk(1'b1, NS_BYTE_HI, 4'h0, 1'b0, EX_NONE,  1'b0);
			5'd15:   w = mk(1'b1, NS_BYTE_LO, 4'h0, 1'b0, EX_NONE,  1'b1);
			5'd16:   w = mk(1'b0, NS_CONST,   4'h0, 1'b0, EX_NONE,  1'b0);
			5'd17:   w = mk(1'b0, NS_CONST,   4'h1, 1'b0, EX_CLEAR, 1'b1);
			5'd18:   w = mk(1'b0, NS_BYTE_HI, 4'h0, 1'b0, EX_NONE,  1'b0);
			5'd19:   w = mk(1'b0, NS_BYTE_LO, 4'h0, 1'b0, EX_NONE,  1'b1);
			default: w = mk(1'b0, NS_CONST,   4'h0, 1'b0, EX_NONE,  1'b1);
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/clns_if.sv -----
`default_nettype none
interface clns_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] opcode;
	logic [7:0] byte_value;
	logic       row;
	logic [5:0] column;

	modport source (output valid, output opcode, output byte_value, output row,
		output column, input ready);
	modport sink (input valid, input opcode, input byte_value, input row,
		input column, output ready);
endinterface

interface clns_xfer_if;
	logic                         valid;
	logic                         ready;
	logic                         reg_select;
	logic [3:0]                   nibble;
	logic [clns_pkg::TIME_W-1:0]  pre_wait;
	logic [clns_pkg::TIME_W-1:0]  strobe_time;
	logic [clns_pkg::POST_W-1:0]  post_wait;
	logic                         last;

	modport source (output valid, output reg_select, output nibble, output pre_wait,
		output strobe_time, output post_wait, output last, input ready);
	modport sink (input valid, input reg_select, input nibble, input pre_wait,
		input strobe_time, input post_wait, input last, output ready);
endinterface

interface clns_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [clns_pkg::CFG_IDX_W-1:0] index;
	logic [clns_pkg::TIME_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/char_lcd_nibble_sequencer.sv -----
`default_nettype none
// Channel  Role   Payload
// req      sink   opcode, byte_value, row, column
// xfer     source reg_select, nibble, pre_wait, strobe_time, post_wait, last
// cfg      sink   index, data (always ready)
//
// A request is taken, then its microcode runs one step per cycle, each step
// loading one nibble transfer into the output register: init loads 12
// transfers, every other request 2. The step counter stalls while the
// output register holds an untaken transfer. req.ready is low while a program
// runs. Reset idles the step counter, clears xfer.valid and loads config defaults.
module char_lcd_nibble_sequencer (
	input wire logic clk,
	input wire logic arst_n,
	clns_req_if.sink    req,
	clns_xfer_if.source xfer,
	clns_cfg_if.sink    cfg
);
	import clns_pkg::*;

	cfg_t      regs;
	ctl_t      ctl;
	seq_stat_t stat;
	logic      out_stall;

	clns_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	clns_useq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.out_stall (out_stall),
		.ctl       (ctl),
		.stat      (stat)
	);

	clns_dpath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.regs      (regs),
		.xfer      (xfer),
		.out_stall (out_stall)
	);

`ifndef NO_ASSERTIONS
	// a running program with a free output always loads a transfer
	a_step_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.busy && !out_stall) |=> xfer.valid)
		else $error("step did not load a transfer");

	// a valid opcode starts a program
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.opcode <= OP_CURSOR) |=> stat.busy)
		else $error("request did not start a program");

	// no request transfer while a program runs
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> !req.ready)
		else $error("request taken while busy");
`endif
endmodule
`default_nettype wire

// ----- rtl/core/clns_cfg_regs.sv -----
`default_nettype none
module clns_cfg_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	clns_cfg_if.sink          cfg,
	output clns_pkg::cfg_t    regs
);
	import clns_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.enable_high_time <= RST_ENABLE_HIGH;
			regs_q.hold_after_pulse <= RST_HOLD_AFTER;
			regs_q.power_on_wait    <= RST_POWER_ON;
			regs_q.wake_nibble_wait <= RST_WAKE_WAIT;
			regs_q.clear_wait       <= RST_CLEAR_WAIT;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_ENABLE_HIGH: regs_q.enable_high_time <= cfg.data;
				CFG_HOLD_AFTER:  regs_q.hold_after_pulse <= cfg.data;
				CFG_POWER_ON:    regs_q.power_on_wait    <= cfg.data;
				CFG_WAKE_WAIT:   regs_q.wake_nibble_wait <= cfg.data;
				CFG_CLEAR_WAIT:  regs_q.clear_wait       <= cfg.data;
				default: begin
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/clns_useq.sv -----
`default_nettype none
module clns_useq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	clns_req_if.sink           req,
	input  wire logic          out_stall,
	output clns_pkg::ctl_t     ctl,
	output clns_pkg::seq_stat_t stat
);
	import clns_pkg::*;

	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	logic [7:0]      byte_q;
	logic [PC_W-1:0] entry;
	logic            op_ok;
	logic            accept;
	logic            fire;
	uword_t          word;

	assign req.ready = !busy_q;
	assign accept    = req.valid && !busy_q;
	assign fire      = busy_q && !out_stall;
	assign word      = ucode_rom(pc_q);

	// dispatch on opcode; unused codes are taken and dropped
	always_comb begin
		op_ok = 1'b1;
		case (opcode_t'(req.opcode))
			OP_INIT:   entry = ENTRY_INIT;
			OP_CMD:    entry = ENTRY_CMD;
			OP_DATA:   entry = ENTRY_DATA;
			OP_CLEAR:  entry = ENTRY_CLEAR;
			OP_CURSOR: entry = ENTRY_CURSOR;
			default: begin
				entry = ENTRY_INIT;
				op_ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
		end else if (accept) begin
			busy_q <= op_ok;
			pc_q   <= entry;
		end else if (fire) begin
			if (word.last) begin
				busy_q <= 1'b0;
			end else begin
				pc_q <= pc_q + PC_W'(1);
			end
		end
	end

	// cursor command is 0x80 | line base | column
	always_ff @(posedge clk) begin
		if (accept) begin
			if (opcode_t'(req.opcode) == OP_CURSOR) begin
				byte_q <= {1'b1, req.row, req.column};
			end else begin
				byte_q <= req.byte_value;
			end
		end
	end

	assign ctl.fire   = fire;
	assign ctl.word   = word;
	assign ctl.byte_q = byte_q;
	assign stat.busy  = busy_q;
endmodule
`default_nettype wire

// ----- rtl/core/clns_dpath.sv -----
`default_nettype none
module clns_dpath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire clns_pkg::ctl_t ctl,
	input  wire clns_pkg::cfg_t regs,
	clns_xfer_if.source        xfer,
	output logic               out_stall
);
	import clns_pkg::*;

	logic              valid_q;
	logic              rs_q;
	logic [3:0]        nib_q;
	logic [TIME_W-1:0] pre_q;
	logic [TIME_W-1:0] strobe_q;
	logic [POST_W-1:0] post_q;
	logic              last_q;

	logic [3:0]        nib_d;
	logic [TIME_W-1:0] extra_d;
	logic [TIME_W-1:0] pre_d;

	assign out_stall = valid_q && !xfer.ready;

	always_comb begin
		case (ctl.word.nsrc)
			NS_BYTE_HI: nib_d = ctl.byte_q[7:4];
			NS_BYTE_LO: nib_d = ctl.byte_q[3:0];
			default:    nib_d = ctl.word.cnib;
		endcase
		case (ctl.word.extra)
			EX_WAKE:  extra_d = regs.wake_nibble_wait;
			EX_CLEAR: extra_d = regs.clear_wait;
			default:  extra_d = '0;
		endcase
		pre_d = ctl.word.pre_power ? regs.power_on_wait : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.fire) begin
			valid_q <= 1'b1;
		end else if (xfer.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fire) begin
			rs_q     <= ctl.word.rs;
			nib_q    <= nib_d;
			pre_q    <= pre_d;
			strobe_q <= regs.enable_high_time;
			post_q   <= {1'b0, regs.hold_after_pulse} + {1'b0, extra_d};
			last_q   <= ctl.word.last;
		end
	end

	assign xfer.valid       = valid_q;
	assign xfer.reg_select  = rs_q;
	assign xfer.nibble      = nib_q;
	assign xfer.pre_wait    = pre_q;
	assign xfer.strobe_time = strobe_q;
	assign xfer.post_wait   = post_q;
	assign xfer.last        = last_q;
endmodule
`default_nettype wire
